// ===== src/ecd_pkg.sv =====
// Shared types, codes and widths of the elevator call dispatcher.
package ecd_pkg;

  // Field widths of the event and command beats.
  localparam int ACTION_W  = 3;
  localparam int FLOOR_W   = 4;
  localparam int COMMAND_W = 3;

  // Default number of floors and depth of the command queue.
  localparam int FLOORS_DEF  = 16;
  localparam int QUEUE_DEPTH = 2;

  // Event codes.
  localparam logic [ACTION_W-1:0] ACT_EXT_CALL    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_INT_CALL    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_SENSOR      = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_DOOR_OPENED = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DOOR_CLOSED = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_DOOR_EXPIRY = 3'd5;

  // Command codes.
  localparam logic [COMMAND_W-1:0] CMD_UP    = 3'd0;
  localparam logic [COMMAND_W-1:0] CMD_DOWN  = 3'd1;
  localparam logic [COMMAND_W-1:0] CMD_STOP  = 3'd2;
  localparam logic [COMMAND_W-1:0] CMD_OPEN  = 3'd3;
  localparam logic [COMMAND_W-1:0] CMD_CLOSE = 3'd4;

  // Commands caused by one event, in order; count runs from zero to two.
  typedef struct packed {
    logic [1:0]           count;
    logic [COMMAND_W-1:0] first;
    logic [COMMAND_W-1:0] second;
  } ecd_cmds_t;

endpackage

// ===== src/ecd_front.sv =====
// Front end: accepts events, updates the car state and forms the commands.
module ecd_front #(
  parameter int FLOORS = ecd_pkg::FLOORS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            fire,
  input  logic [ecd_pkg::ACTION_W-1:0]    action,
  input  logic [ecd_pkg::FLOOR_W-1:0]     floor,
  output logic                            push,
  output ecd_pkg::ecd_cmds_t              cmds
);

  logic [ecd_pkg::FLOOR_W-1:0] current_floor, current_floor_next;
  logic [ecd_pkg::FLOOR_W-1:0] target_floor, target_floor_next;
  logic                        target_valid, target_valid_next;
  logic [FLOORS-1:0]           pending_floors, pending_floors_next;
  logic                        more_pending, more_pending_next;
  logic                        moved_since_call, moved_since_call_next;
  logic                        door_waiting, door_waiting_next;

  logic [FLOORS-1:0]           floor_onehot;
  logic [FLOORS-1:0]           pending_set;
  logic                        floor_ok;
  logic                        ignored;
  logic [ecd_pkg::FLOOR_W-1:0] high_idx, low_idx;
  logic                        low_found;
  logic                        dir_valid;
  logic [ecd_pkg::COMMAND_W-1:0] dir_cmd;
  logic                        a_valid, b_valid;
  logic [ecd_pkg::COMMAND_W-1:0] a_cmd, b_cmd;

  // Highest set bit; the index wraps to the floor field width.
  function automatic logic [ecd_pkg::FLOOR_W-1:0] highest(input logic [FLOORS-1:0] v);
    logic [ecd_pkg::FLOOR_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < FLOORS; i++) begin
      if (v[i]) begin
        idx = ecd_pkg::FLOOR_W'(i);
      end
    end
    return idx;
  endfunction

  // Lowest set bit; the index wraps to the floor field width.
  function automatic logic [ecd_pkg::FLOOR_W-1:0] lowest(input logic [FLOORS-1:0] v);
    logic [ecd_pkg::FLOOR_W-1:0] idx;
    idx = '0;
    for (int i = FLOORS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = ecd_pkg::FLOOR_W'(i);
      end
    end
    return idx;
  endfunction

  // Floor decode; a floor past the top of the building selects no bit.
  assign floor_onehot = {{(FLOORS-1){1'b0}}, 1'b1} << floor;
  assign floor_ok     = (32'(floor) < 32'(FLOORS));
  assign pending_set  = pending_floors | floor_onehot;
  assign high_idx     = highest(pending_set);
  assign low_idx      = lowest(pending_floors);
  assign low_found    = |pending_floors;

  // While the door wait runs only its expiry counts; otherwise expiry and
  // the unused codes are dropped.
  assign ignored = door_waiting ? (action != ecd_pkg::ACT_DOOR_EXPIRY)
                                : (action >= ecd_pkg::ACT_DOOR_EXPIRY);

  // Next state of the car.
  always_comb begin
    current_floor_next    = current_floor;
    target_floor_next     = target_floor;
    target_valid_next     = target_valid;
    pending_floors_next   = pending_floors;
    more_pending_next     = more_pending;
    moved_since_call_next = moved_since_call;
    door_waiting_next     = door_waiting;
    a_valid               = 1'b0;
    a_cmd                 = ecd_pkg::CMD_STOP;
    unique case (action)
      ecd_pkg::ACT_EXT_CALL: begin
        if (floor_ok) begin
          pending_floors_next = pending_set;
          if (!target_valid || (!more_pending && moved_since_call)) begin
            moved_since_call_next = 1'b0;
            target_floor_next     = floor;
            target_valid_next     = 1'b1;
          end
        end
      end
      ecd_pkg::ACT_INT_CALL: begin
        if (floor_ok) begin
          pending_floors_next = pending_set;
          target_floor_next   = high_idx;
          target_valid_next   = 1'b1;
        end
      end
      ecd_pkg::ACT_SENSOR: begin
        moved_since_call_next = 1'b1;
        current_floor_next    = floor;
        if (target_valid && floor == target_floor) begin
          pending_floors_next = pending_floors & ~floor_onehot;
          door_waiting_next   = 1'b1;
        end
      end
      ecd_pkg::ACT_DOOR_OPENED: begin
        a_valid = 1'b1;
        a_cmd   = ecd_pkg::CMD_CLOSE;
      end
      ecd_pkg::ACT_DOOR_EXPIRY: begin
        door_waiting_next = 1'b0;
        more_pending_next = low_found;
        if (low_found) begin
          target_floor_next = low_idx;
          target_valid_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Direction toward the target, from the updated state.
  assign dir_valid = target_valid_next && (current_floor_next != target_floor_next);
  assign dir_cmd   = (current_floor_next < target_floor_next) ? ecd_pkg::CMD_UP
                                                              : ecd_pkg::CMD_DOWN;

  // Command list: an optional leading command, then an optional second one.
  always_comb begin
    b_valid = more_pending_next && dir_valid;
    b_cmd   = dir_cmd;
    cmds    = '0;
    if (action == ecd_pkg::ACT_SENSOR && door_waiting_next) begin
      cmds.count  = 2'd2;
      cmds.first  = ecd_pkg::CMD_STOP;
      cmds.second = ecd_pkg::CMD_OPEN;
    end else begin
      priority if ((action == ecd_pkg::ACT_EXT_CALL || action == ecd_pkg::ACT_INT_CALL)
                   && floor_ok) begin
        if (dir_valid) begin
          cmds.count  = b_valid ? 2'd2 : 2'd1;
          cmds.first  = dir_cmd;
          cmds.second = dir_cmd;
        end
      end else if (a_valid) begin
        cmds.count  = b_valid ? 2'd2 : 2'd1;
        cmds.first  = a_cmd;
        cmds.second = b_cmd;
      end else if (b_valid) begin
        cmds.count = 2'd1;
        cmds.first = b_cmd;
      end else begin
        cmds.count = 2'd0;
      end
    end
  end

  assign push = fire && !ignored && (cmds.count != 2'd0);

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_floor    <= '0;
      target_floor     <= '0;
      target_valid     <= 1'b0;
      pending_floors   <= '0;
      more_pending     <= 1'b0;
      moved_since_call <= 1'b0;
      door_waiting     <= 1'b0;
    end else if (fire && !ignored) begin
      current_floor    <= current_floor_next;
      target_floor     <= target_floor_next;
      target_valid     <= target_valid_next;
      pending_floors   <= pending_floors_next;
      more_pending     <= more_pending_next;
      moved_since_call <= moved_since_call_next;
      door_waiting     <= door_waiting_next;
    end
  end

endmodule

// ===== src/ecd_queue.sv =====
// Short queue of command pairs between the front end and the back end.
module ecd_queue #(
  parameter int DEPTH = ecd_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ecd_pkg::ecd_cmds_t push_data,
  input  logic               pop,
  output logic               full,
  output logic               head_valid,
  output ecd_pkg::ecd_cmds_t head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ecd_pkg::ecd_cmds_t entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   fill;

  assign full       = (fill == CNT_W'(DEPTH));
  assign head_valid = (fill != '0);
  assign head_data  = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== src/ecd_back.sv =====
// Back end: turns queued command pairs into output beats.
module ecd_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              head_valid,
  input  ecd_pkg::ecd_cmds_t                head_data,
  output logic                              pop,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ecd_pkg::COMMAND_W-1:0]     command,
  output logic                              last
);

  logic                          hold_valid;
  logic [ecd_pkg::COMMAND_W-1:0] hold_cmd;
  logic                          load;

  // The output register takes a new beat when empty or being drained.
  assign load = !m_tvalid || m_tready;
  assign pop  = load && !hold_valid && head_valid;

  // Control: output valid and the held second command.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      hold_valid <= 1'b0;
    end else if (load) begin
      if (hold_valid) begin
        m_tvalid   <= 1'b1;
        hold_valid <= 1'b0;
      end else if (head_valid) begin
        m_tvalid   <= 1'b1;
        hold_valid <= (head_data.count == 2'd2);
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload of the output beat and the held command.
  always_ff @(posedge clk) begin
    if (load) begin
      if (hold_valid) begin
        command <= hold_cmd;
        last    <= 1'b1;
      end else if (head_valid) begin
        command  <= head_data.first;
        last     <= (head_data.count == 2'd1);
        hold_cmd <= head_data.second;
      end
    end
  end

endmodule

// ===== src/elevator_call_dispatcher.sv =====
// Top level of the elevator call dispatcher for one car.
//
// Usage: events enter on the slave stream (s_*), one per beat: the event
// kind in s_tuser and the floor in s_tdata. Commands leave on the master
// stream (m_*), one per beat, with tlast on the final command of an event.
// An event causes zero, one or two commands; events that cause none, and
// events ignored during the door wait, leave nothing on the output.
// The first command of an event passes from the queue into the output
// register. Throughput: one event per cycle on the input while the queue
// is not full, one command per cycle on the output while m_tready is
// high; the two commands of an event leave the single output port one
// after the other. A two-entry queue of command pairs separates the
// state update from the output register.
// When the receiver stalls, commands wait in the output register and the
// queue; s_tready drops only while the queue is full.
// Reset (synchronous, active high) clears the car state, empties the queue
// and drops m_tvalid; s_tready is high in the first cycle after reset.
module elevator_call_dispatcher #(
  parameter int FLOORS = ecd_pkg::FLOORS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [3:0] floor, [7:4] zero
  input  logic [2:0] s_tuser,   // [2:0] action
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [2:0] command, [7:3] zero
  output logic       m_tlast    // last command of the event
);

  logic                          fire;
  logic                          push;
  logic                          full;
  logic                          pop;
  logic                          head_valid;
  ecd_pkg::ecd_cmds_t            cmds;
  ecd_pkg::ecd_cmds_t            head_data;
  logic [ecd_pkg::COMMAND_W-1:0] command;

  assign s_tready = !full;
  assign fire     = s_tvalid && s_tready;
  assign m_tdata  = {(8 - ecd_pkg::COMMAND_W)'(0), command};

  // State update and command forming.
  ecd_front #(.FLOORS(FLOORS)) u_front (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .action (s_tuser),
    .floor  (s_tdata[ecd_pkg::FLOOR_W-1:0]),
    .push   (push),
    .cmds   (cmds)
  );

  // Queue of command pairs.
  ecd_queue #(.DEPTH(ecd_pkg::QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (cmds),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  // Output beats.
  ecd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .command    (command),
    .last       (m_tlast)
  );

endmodule

// ===== src/ecd_checker.sv =====
// Port-level checks of the elevator call dispatcher and their binding.
module ecd_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic [2:0] s_tuser,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // A stalled output beat holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output beat changed");

  // After reset the output is empty and the input is open.
  assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("output not empty or input closed after reset");

  // The second command of an event follows at once.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("second command of an event did not follow");

  // A stop that is not last is always followed by the door open.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast && m_tdata[2:0] == ecd_pkg::CMD_STOP
    |=> m_tdata[2:0] == ecd_pkg::CMD_OPEN && m_tlast)
    else $error("stop not followed by open");

  // Commands carry a known code and zero padding.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] <= ecd_pkg::CMD_CLOSE && m_tdata[7:3] == 5'd0)
    else $error("bad command code");

endmodule

bind elevator_call_dispatcher ecd_checker u_ecd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ===== test/testbench.sv =====
// Self-checking testbench for the elevator call dispatcher: event stimulus and command checks.
`timescale 1ns / 100ps

// One command beat as it should leave the block.
typedef struct {
  logic [ecd_pkg::COMMAND_W-1:0] command;
  logic                          last;
} car_cmd_t;

// Tracks the car state, works out the commands for each accepted event and
// checks every command beat against the oldest one still owed.
class car_scoreboard;
  logic [ecd_pkg::FLOOR_W-1:0]    cur_floor;
  logic [ecd_pkg::FLOOR_W-1:0]    tgt_floor;
  logic                           tgt_valid;
  logic                           more_pending;
  logic                           moved;
  logic                           door_wait;
  logic [ecd_pkg::FLOORS_DEF-1:0] call_map;
  logic [ecd_pkg::COMMAND_W-1:0]  burst[$];
  car_cmd_t                       owed_cmds[$];
  int                             errors;

  function new();
    cur_floor    = '0;
    tgt_floor    = '0;
    tgt_valid    = 1'b0;
    more_pending = 1'b0;
    moved        = 1'b0;
    door_wait    = 1'b0;
    call_map     = '0;
    errors       = 0;
  endfunction

  // Direction toward the target; nothing when there is no target or the car is there.
  function void add_heading();
    if (tgt_valid) begin
      if (cur_floor < tgt_floor) begin
        burst.push_back(ecd_pkg::CMD_UP);
      end else if (cur_floor > tgt_floor) begin
        burst.push_back(ecd_pkg::CMD_DOWN);
      end
    end
  endfunction

  // Applies one accepted event; events the block ignores change nothing.
  function void note_event(logic [ecd_pkg::ACTION_W-1:0] act,
                           logic [ecd_pkg::FLOOR_W-1:0] flr);
    bit trailing;
    trailing = 1'b1;
    burst.delete();

    // During the door wait only expiry counts; outside it expiry and unknown codes are dropped.
    if (door_wait ? (act != ecd_pkg::ACT_DOOR_EXPIRY) : (act >= ecd_pkg::ACT_DOOR_EXPIRY)) begin
      return;
    end

    case (act)
      ecd_pkg::ACT_EXT_CALL: begin
        if (flr < ecd_pkg::FLOORS_DEF) begin
          call_map[flr] = 1'b1;
          // A hall call takes over the target only on the first call, or after
          // the car has moved with nothing else queued.
          if (!tgt_valid || (!more_pending && moved)) begin
            moved     = 1'b0;
            tgt_floor = flr;
            tgt_valid = 1'b1;
          end
          add_heading();
        end
      end
      ecd_pkg::ACT_INT_CALL: begin
        if (flr < ecd_pkg::FLOORS_DEF) begin
          call_map[flr] = 1'b1;
          // Cabin calls aim at the highest requested floor.
          for (int i = 0; i < ecd_pkg::FLOORS_DEF; i++) begin
            if (call_map[i]) begin
              tgt_floor = ecd_pkg::FLOOR_W'(i);
              tgt_valid = 1'b1;
            end
          end
          add_heading();
        end
      end
      ecd_pkg::ACT_SENSOR: begin
        moved     = 1'b1;
        cur_floor = flr;
        if (tgt_valid && cur_floor == tgt_floor) begin
          call_map[flr] = 1'b0;
          burst.push_back(ecd_pkg::CMD_STOP);
          burst.push_back(ecd_pkg::CMD_OPEN);
          door_wait = 1'b1;
          trailing  = 1'b0;
        end
      end
      ecd_pkg::ACT_DOOR_OPENED: begin
        burst.push_back(ecd_pkg::CMD_CLOSE);
      end
      ecd_pkg::ACT_DOOR_CLOSED: begin
      end
      default: begin
        // Door wait over: head for the lowest requested floor, keep the target if none.
        door_wait    = 1'b0;
        more_pending = 1'b0;
        for (int i = 0; i < ecd_pkg::FLOORS_DEF; i++) begin
          if (call_map[i]) begin
            tgt_floor    = ecd_pkg::FLOOR_W'(i);
            tgt_valid    = 1'b1;
            more_pending = 1'b1;
            break;
          end
        end
      end
    endcase

    if (trailing && more_pending && burst.size() < 2) begin
      add_heading();
    end

    foreach (burst[i]) begin
      owed_cmds.push_back('{command: burst[i], last: (i == burst.size() - 1)});
    end
  endfunction

  // Compares one command beat with the oldest owed command.
  function void check_command(logic [ecd_pkg::COMMAND_W-1:0] command, logic last);
    car_cmd_t want;
    if (owed_cmds.size() == 0) begin
      errors++;
      $error("command: expected none, actual %0d", command);
      return;
    end
    want = owed_cmds.pop_front();
    if (command !== want.command) begin
      errors++;
      $error("command: expected %0d, actual %0d", want.command, command);
    end
    if (last !== want.last) begin
      errors++;
      $error("last: expected %0d, actual %0d", want.last, last);
    end
  endfunction
endclass

module testbench;
  localparam logic [ecd_pkg::ACTION_W-1:0] ACT_RESERVED_LO = 3'd6;
  localparam logic [ecd_pkg::ACTION_W-1:0] ACT_RESERVED_HI = 3'd7;
  localparam int IDLE_PERCENT = 15;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 10;
  localparam int LIMIT_CYCLES = 200000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;   // [3:0] floor, [7:4] zero
  logic [2:0] s_tuser = '0;   // [2:0] action
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;        // [2:0] command, [7:3] zero
  logic       m_tlast;

  car_scoreboard sb;
  bit            idle_on    = 1'b1;
  bit            hold_start = 1'b0;
  int            cycle_count = 0;

  elevator_call_dispatcher DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Command receiver: checks each accepted beat, then picks tready for the next edge.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        sb.check_command(m_tdata[ecd_pkg::COMMAND_W-1:0], m_tlast);
      end
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !(idle_on && $urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  // Offers one event beat and waits for its handshake; valid stays high afterwards.
  task automatic send_event(input logic [ecd_pkg::ACTION_W-1:0] act,
                            input logic [ecd_pkg::FLOOR_W-1:0] flr);
    while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, flr};
    s_tuser  <= act;
    do begin
      @(posedge clk);
    end while (!s_tready);
    sb.note_event(act, flr);
  endtask

  task automatic drive(input logic [ecd_pkg::ACTION_W-1:0] act,
                       input logic [ecd_pkg::FLOOR_W-1:0] flr);
    send_event(act, flr);
  endtask

  // Random events, mostly plausible for the current car state, until count are sent.
  task automatic run_random(input int count);
    logic [ecd_pkg::ACTION_W-1:0] act;
    logic [ecd_pkg::FLOOR_W-1:0]  flr;
    int                           pick;
    int                           sent;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      flr  = ecd_pkg::FLOOR_W'($urandom_range(ecd_pkg::FLOORS_DEF - 1));
      if (sb.door_wait) begin
        act = (pick < 85) ? ecd_pkg::ACT_DOOR_EXPIRY
                          : ecd_pkg::ACTION_W'($urandom_range(ACT_RESERVED_HI));
      end else if (pick < 20) begin
        act = ecd_pkg::ACT_EXT_CALL;
      end else if (pick < 35) begin
        act = ecd_pkg::ACT_INT_CALL;
      end else if (pick < 70) begin
        act = ecd_pkg::ACT_SENSOR;
        // Half the sensor beats land on the target so arrivals happen often.
        if ($urandom_range(1)) begin
          flr = sb.tgt_floor;
        end
      end else if (pick < 80) begin
        act = ecd_pkg::ACT_DOOR_OPENED;
      end else if (pick < 88) begin
        act = ecd_pkg::ACT_DOOR_CLOSED;
      end else if (pick < 94) begin
        act = ecd_pkg::ACT_DOOR_EXPIRY;
      end else begin
        act = ecd_pkg::ACTION_W'($urandom_range(ACT_RESERVED_HI));
      end
      send_event(act, flr);
      sent++;
    end
  endtask

  // Stops offering events and waits until every owed command has left the block.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do begin
      @(posedge clk);
    end while (sb.owed_cmds.size() != 0);
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed walk: idle events, the first call, retargeting, arrivals and door waits.
    drive(ecd_pkg::ACT_DOOR_OPENED, 4'd0);     // close with nothing pending
    drive(ecd_pkg::ACT_DOOR_CLOSED, 4'd0);
    drive(ecd_pkg::ACT_DOOR_EXPIRY, 4'd0);     // expiry outside a door wait is dropped
    drive(ACT_RESERVED_LO, 4'd0);
    drive(ACT_RESERVED_HI, 4'd15);
    drive(ecd_pkg::ACT_SENSOR, 4'd0);          // no target yet
    drive(ecd_pkg::ACT_EXT_CALL, 4'd15);       // first call sets the target
    drive(ecd_pkg::ACT_EXT_CALL, 4'd3);        // does not retarget
    drive(ecd_pkg::ACT_INT_CALL, 4'd9);        // highest pending stays the top floor
    drive(ecd_pkg::ACT_SENSOR, 4'd15);         // arrival: stop and open
    drive(ecd_pkg::ACT_EXT_CALL, 4'd5);        // ignored during the door wait
    drive(ecd_pkg::ACT_DOOR_OPENED, 4'd0);     // ignored during the door wait
    drive(ecd_pkg::ACT_DOOR_EXPIRY, 4'd0);     // head for the lowest pending floor
    drive(ecd_pkg::ACT_INT_CALL, 4'd0);        // direction twice while more are pending
    drive(ecd_pkg::ACT_DOOR_OPENED, 4'd0);     // close plus direction
    drive(ecd_pkg::ACT_SENSOR, 4'd9);
    drive(ecd_pkg::ACT_DOOR_EXPIRY, 4'd0);
    drive(ecd_pkg::ACT_SENSOR, 4'd0);
    drive(ecd_pkg::ACT_DOOR_EXPIRY, 4'd0);
    drive(ecd_pkg::ACT_SENSOR, 4'd3);
    drive(ecd_pkg::ACT_DOOR_EXPIRY, 4'd0);     // nothing pending: target kept
    drive(ecd_pkg::ACT_SENSOR, 4'd3);          // arrival on a floor whose bit is already clear
    drive(ecd_pkg::ACT_DOOR_EXPIRY, 4'd0);
    drive(ecd_pkg::ACT_SENSOR, 4'd12);
    drive(ecd_pkg::ACT_EXT_CALL, 4'd0);        // car moved, nothing queued: call retargets
    wait_drained();

    // Random phases: plain, with a long receiver hold, without idling, plain again, then after a pause.
    run_random(300);
    hold_start = 1'b1;
    run_random(100);
    idle_on = 1'b0;
    run_random(300);
    idle_on = 1'b1;
    run_random(200);
    wait_drained();
    run_random(600);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.owed_cmds.size() != 0) begin
      sb.errors++;
      $error("command: expected %0d more beats, actual none", sb.owed_cmds.size());
    end
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
src/ecd_pkg.sv
src/ecd_front.sv
src/ecd_queue.sv
src/ecd_back.sv
src/elevator_call_dispatcher.sv
src/ecd_checker.sv
test/testbench.sv
